// ===== hdl/bdr_pkg.sv =====
// Shared constants, types and tables for the button debounce / repeat core.
// No dependencies; used by every module in hdl/.
package bdr_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int NUM_PAIRS   = 3;
  localparam int CNT_W       = 8;
  localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_DELAY     = 1'd1;

  // Register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_COUNT_RST = 8'd4;
  localparam logic [CNT_W-1:0] HOLD_DELAY_RST     = 8'd50;

  // Pair members: AB, BC, AC
  localparam logic [BTN_IDX_W-1:0] PAIR_FIRST  [NUM_PAIRS] = '{2'd0, 2'd1, 2'd0};
  localparam logic [BTN_IDX_W-1:0] PAIR_SECOND [NUM_PAIRS] = '{2'd1, 2'd2, 2'd2};

  // Events produced for one poll tick
  typedef struct packed {
    logic [NUM_PAIRS-1:0]   combo;  // ab, bc, ac from bit 0 up
    logic [NUM_BUTTONS-1:0] press;  // a, b, c from bit 0 up
  } bdr_event_t;

endpackage

// ===== hdl/bdr_debounce.sv =====
// Counter debouncer for one button; raw_pressed is high while pressed.
// Depends on bdr_pkg for the counter width.
module bdr_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      raw_pressed,
  input  logic [bdr_pkg::CNT_W-1:0] debounce_count,
  output logic                      held_r,
  output logic                      held_nxt
);

  logic [bdr_pkg::CNT_W-1:0] bounce_r;
  logic [bdr_pkg::CNT_W-1:0] bounce_nxt;
  logic [bdr_pkg::CNT_W:0]   bounce_inc;

  // Count differing ticks, flip the stable level when the count is reached
  always_comb begin
    bounce_inc = {1'b0, bounce_r} + {{bdr_pkg::CNT_W{1'b0}}, 1'b1};
    held_nxt   = held_r;
    bounce_nxt = '0;
    if (raw_pressed != held_r) begin
      if (bounce_inc >= {1'b0, debounce_count}) begin
        held_nxt = ~held_r;
      end else begin
        bounce_nxt = bounce_inc[bdr_pkg::CNT_W-1:0];
      end
    end
  end

  // Advance only on a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      bounce_r <= '0;
    end else if (en) begin
      held_r   <= held_nxt;
      bounce_r <= bounce_nxt;
    end
  end

endmodule

// ===== hdl/bdr_hold.sv =====
// Press pulse / hold repeat for each button and single-shot pair combos.
// Depends on bdr_pkg for widths, pair tables and the event struct.
module bdr_hold (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [bdr_pkg::NUM_BUTTONS-1:0] held,
  input  logic [bdr_pkg::CNT_W-1:0]       hold_delay,
  output bdr_pkg::bdr_event_t             ev
);

  logic [bdr_pkg::CNT_W-1:0] hold_r   [bdr_pkg::NUM_BUTTONS];
  logic [bdr_pkg::CNT_W-1:0] hold_nxt [bdr_pkg::NUM_BUTTONS];
  logic [bdr_pkg::NUM_PAIRS-1:0] pair_on_r;
  logic [bdr_pkg::NUM_PAIRS-1:0] pair_on_nxt;
  logic [bdr_pkg::NUM_PAIRS-1:0] pair_both;
  logic [bdr_pkg::NUM_BUTTONS-1:0] press_ev;
  logic [bdr_pkg::NUM_PAIRS-1:0]   combo_ev;

  // Single buttons: pulse on first held tick, mute until the delay, then hold
  always_comb begin
    for (int i = 0; i < bdr_pkg::NUM_BUTTONS; i++) begin
      hold_nxt[i] = '0;
      press_ev[i] = 1'b0;
      if (held[i]) begin
        hold_nxt[i] = hold_r[i];
        if (hold_r[i] == '0) begin
          hold_nxt[i] = {{(bdr_pkg::CNT_W-1){1'b0}}, 1'b1};
          press_ev[i] = 1'b1;
        end else if (hold_r[i] < hold_delay) begin
          hold_nxt[i] = hold_r[i] + {{(bdr_pkg::CNT_W-1){1'b0}}, 1'b1};
        end else begin
          press_ev[i] = 1'b1;
        end
      end
    end
  end

  // Pairs: one pulse when both are held, rearm on release
  always_comb begin
    for (int p = 0; p < bdr_pkg::NUM_PAIRS; p++) begin
      pair_both[p]   = held[bdr_pkg::PAIR_FIRST[p]] & held[bdr_pkg::PAIR_SECOND[p]];
      pair_on_nxt[p] = pair_both[p];
      combo_ev[p]    = pair_both[p] & ~pair_on_r[p];
    end
  end

  assign ev = {combo_ev, press_ev};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bdr_pkg::NUM_BUTTONS; i++) begin
        hold_r[i] <= '0;
      end
      pair_on_r <= '0;
    end else if (en) begin
      for (int i = 0; i < bdr_pkg::NUM_BUTTONS; i++) begin
        hold_r[i] <= hold_nxt[i];
      end
      pair_on_r <= pair_on_nxt;
    end
  end

endmodule

// ===== hdl/button_debounce_repeat_core.sv =====
// Button debounce / repeat core. A tick passes from the input register through
// the event logic into the output register.
// Throughput: one poll tick per cycle, limited only by the output handshake.
// Reset (synchronous, rst_n low): buttons released, all counters zero,
// debounce_count = 4, hold_delay = 50, both pipeline registers empty.
// Uses bdr_pkg, bdr_debounce and bdr_hold.
module button_debounce_repeat_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] pin_a, [1] pin_b, [2] pin_c, [7:3] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] press_a, [1] press_b, [2] press_c,
                                 // [3] combo_ab, [4] combo_bc, [5] combo_ac, [7:6] zero
  input  logic                                cfg_we,
  input  logic [bdr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bdr_pkg::CNT_W-1:0]           cfg_wdata
);

  logic [bdr_pkg::CNT_W-1:0]       debounce_count_r;
  logic [bdr_pkg::CNT_W-1:0]       hold_delay_r;
  logic                            s1_valid_r;
  logic [bdr_pkg::NUM_BUTTONS-1:0] s1_pins_r;
  logic                            out_valid_r;
  bdr_pkg::bdr_event_t             out_ev_r;
  logic                            advance;
  logic [bdr_pkg::NUM_BUTTONS-1:0] held_r;
  logic [bdr_pkg::NUM_BUTTONS-1:0] held_nxt;
  bdr_pkg::bdr_event_t             ev;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= bdr_pkg::DEBOUNCE_COUNT_RST;
      hold_delay_r     <= bdr_pkg::HOLD_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bdr_pkg::CFG_DEBOUNCE_COUNT: debounce_count_r <= cfg_wdata;
        bdr_pkg::CFG_HOLD_DELAY:     hold_delay_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Move a tick from the input register to the output register when there is room
  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pins_r <= in_tdata[bdr_pkg::NUM_BUTTONS-1:0];
    end
  end

  // Debounce each button; pins are active low
  for (genvar g = 0; g < bdr_pkg::NUM_BUTTONS; g++) begin : g_btn
    bdr_debounce u_debounce (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (advance),
      .raw_pressed    (~s1_pins_r[g]),
      .debounce_count (debounce_count_r),
      .held_r         (held_r[g]),
      .held_nxt       (held_nxt[g])
    );
  end

  bdr_hold u_hold (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .held       (held_nxt),
    .hold_delay (hold_delay_r),
    .ev         (ev)
  );

  // Output register: load on advance, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_ev_r.combo, out_ev_r.press};

`ifndef SYNTH
  // Reset leaves buttons released and the output empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (held_r == '0) && !out_tvalid)
    else $error("state not cleared by reset");

  // Debounce state only moves when a tick advances
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(held_r))
    else $error("debounce state changed without a tick");

  // An empty output register never stalls the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
